/* rtl/tlcs_pkg.sv */
// shared types, opcodes and action decode for the tft lcd command sequencer
`timescale 1ns / 1ps
`default_nettype none
package tlcs_pkg;

   // request and result payloads
   typedef struct packed {
      logic       action;
      logic [8:0] pos_x;
      logic [8:0] pos_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef enum logic [2:0] {
      KIND_CMD    = 3'd0,
      KIND_DATA   = 3'd1,
      KIND_RESET  = 3'd2,
      KIND_SELECT = 3'd3,
      KIND_WAIT   = 3'd4,
      KIND_ZEROS  = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [17:0] value;
      logic        last;
   } rsp_type;

   // request codes
   localparam logic ACTION_INIT  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   // register indexes
   localparam logic CSR_PANEL_WIDTH  = 1'b0;
   localparam logic CSR_PANEL_HEIGHT = 1'b1;

   localparam logic [8:0] PANEL_WIDTH_RESET  = 9'd240;
   localparam logic [8:0] PANEL_HEIGHT_RESET = 9'd320;

   // controller opcodes
   localparam logic [7:0] OP_SWRESET = 8'h01;
   localparam logic [7:0] OP_SLPOUT  = 8'h11;
   localparam logic [7:0] OP_COLMOD  = 8'h3A;
   localparam logic [7:0] OP_MADCTL  = 8'h36;
   localparam logic [7:0] OP_INVON   = 8'h21;
   localparam logic [7:0] OP_NORON   = 8'h13;
   localparam logic [7:0] OP_CASET   = 8'h2A;
   localparam logic [7:0] OP_RASET   = 8'h2B;
   localparam logic [7:0] OP_RAMWR   = 8'h2C;
   localparam logic [7:0] OP_DISPON  = 8'h29;
   localparam logic [7:0] MODE_RGB565 = 8'h55;

   localparam logic [17:0] WAIT_RESET_MS = 18'd10;
   localparam logic [17:0] WAIT_LONG_MS  = 18'd120;
   localparam logic [17:0] WAIT_SWRST_MS = 18'd5;
   localparam logic [17:0] VALUE_MAX     = 18'h3FFFF;

   localparam int unsigned INIT_STEPS  = 33;
   localparam int unsigned PIXEL_STEPS = 15;
   localparam int unsigned STEP_W      = $clog2(INIT_STEPS);

   localparam logic [STEP_W-1:0] INIT_LAST  = STEP_W'(INIT_STEPS - 1);
   localparam logic [STEP_W-1:0] PIXEL_LAST = STEP_W'(PIXEL_STEPS - 1);

   // classified request held between front and back
   typedef struct packed {
      logic        action;
      logic [8:0]  pos_x;
      logic [8:0]  pos_y;
      logic [7:0]  color_hi;
      logic [7:0]  color_lo;
      logic [15:0] col_end;
      logic [15:0] row_end;
      logic [17:0] zeros;
   } cmd_type;

   // queue head handed from front to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   function automatic rsp_type mk(input kind_type k, input logic [17:0] v);
      rsp_type r;
      r.kind  = k;
      r.value = v;
      r.last  = 1'b0;
      return r;
   endfunction

   function automatic logic [17:0] byt(input logic [7:0] b);
      return {10'd0, b};
   endfunction

   // one bus action of an init request
   function automatic rsp_type init_action(input cmd_type c, input logic [STEP_W-1:0] s);
      rsp_type r;
      unique case (s)
         6'd0:  r = mk(KIND_RESET, 18'd1);
         6'd1:  r = mk(KIND_SELECT, 18'd1);
         6'd2:  r = mk(KIND_RESET, 18'd0);
         6'd3:  r = mk(KIND_WAIT, WAIT_RESET_MS);
         6'd4:  r = mk(KIND_RESET, 18'd1);
         6'd5:  r = mk(KIND_WAIT, WAIT_LONG_MS);
         6'd6:  r = mk(KIND_SELECT, 18'd0);
         6'd7:  r = mk(KIND_CMD, byt(OP_SWRESET));
         6'd8:  r = mk(KIND_SELECT, 18'd1);
         6'd9:  r = mk(KIND_WAIT, WAIT_SWRST_MS);
         6'd10: r = mk(KIND_SELECT, 18'd0);
         6'd11: r = mk(KIND_CMD, byt(OP_SLPOUT));
         6'd12: r = mk(KIND_WAIT, WAIT_LONG_MS);
         6'd13: r = mk(KIND_CMD, byt(OP_COLMOD));
         6'd14: r = mk(KIND_DATA, byt(MODE_RGB565));
         6'd15: r = mk(KIND_CMD, byt(OP_MADCTL));
         6'd16: r = mk(KIND_DATA, 18'd0);
         6'd17: r = mk(KIND_CMD, byt(OP_INVON));
         6'd18: r = mk(KIND_CMD, byt(OP_NORON));
         6'd19: r = mk(KIND_CMD, byt(OP_CASET));
         6'd20: r = mk(KIND_DATA, 18'd0);
         6'd21: r = mk(KIND_DATA, 18'd0);
         6'd22: r = mk(KIND_DATA, byt(c.col_end[15:8]));
         6'd23: r = mk(KIND_DATA, byt(c.col_end[7:0]));
         6'd24: r = mk(KIND_CMD, byt(OP_RASET));
         6'd25: r = mk(KIND_DATA, 18'd0);
         6'd26: r = mk(KIND_DATA, 18'd0);
         6'd27: r = mk(KIND_DATA, byt(c.row_end[15:8]));
         6'd28: r = mk(KIND_DATA, byt(c.row_end[7:0]));
         6'd29: r = mk(KIND_CMD, byt(OP_RAMWR));
         6'd30: r = mk(KIND_ZEROS, c.zeros);
         6'd31: r = mk(KIND_CMD, byt(OP_DISPON));
         default: r = mk(KIND_SELECT, 18'd1);
      endcase
      return r;
   endfunction

   // one bus action of a pixel request
   function automatic rsp_type pixel_action(input cmd_type c, input logic [STEP_W-1:0] s);
      rsp_type     r;
      logic [17:0] x_hi;
      logic [17:0] x_lo;
      logic [17:0] y_hi;
      logic [17:0] y_lo;
      x_hi = {17'd0, c.pos_x[8]};
      x_lo = byt(c.pos_x[7:0]);
      y_hi = {17'd0, c.pos_y[8]};
      y_lo = byt(c.pos_y[7:0]);
      unique case (s)
         6'd0:  r = mk(KIND_SELECT, 18'd0);
         6'd1:  r = mk(KIND_CMD, byt(OP_CASET));
         6'd2:  r = mk(KIND_DATA, x_hi);
         6'd3:  r = mk(KIND_DATA, x_lo);
         6'd4:  r = mk(KIND_DATA, x_hi);
         6'd5:  r = mk(KIND_DATA, x_lo);
         6'd6:  r = mk(KIND_CMD, byt(OP_RASET));
         6'd7:  r = mk(KIND_DATA, y_hi);
         6'd8:  r = mk(KIND_DATA, y_lo);
         6'd9:  r = mk(KIND_DATA, y_hi);
         6'd10: r = mk(KIND_DATA, y_lo);
         6'd11: r = mk(KIND_CMD, byt(OP_RAMWR));
         6'd12: r = mk(KIND_DATA, byt(c.color_hi));
         6'd13: r = mk(KIND_DATA, byt(c.color_lo));
         default: r = mk(KIND_SELECT, 18'd1);
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/tlcs_front.sv */
// request front end: panel registers, request classification and command queue
`timescale 1ns / 1ps
`default_nettype none
module tlcs_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   output logic             full,
   input  tlcs_pkg::req_type req_item,
   input  wire              csr_valid,
   input  wire              csr_index,
   input  wire [8:0]        csr_data,
   output tlcs_pkg::head_type head,
   input  wire              head_pop
);
   import tlcs_pkg::*;

   logic [8:0]  width_ff, width_in;
   logic [8:0]  height_ff, height_in;
   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cmd;
   logic [17:0] area;
   logic [18:0] zeros_raw;
   logic        do_push;
   logic        do_pop;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PANEL_WIDTH:  width_in  = csr_data;
            CSR_PANEL_HEIGHT: height_in = csr_data;
            default:          width_in  = width_ff;
         endcase
      end
   end

   // classify: pack the color and precompute window ends and clear count
   always_comb begin
      area      = 18'(width_ff) * 18'(height_ff);
      zeros_raw = {area, 1'b0};
      cmd.action   = req_item.action;
      cmd.pos_x    = req_item.pos_x;
      cmd.pos_y    = req_item.pos_y;
      cmd.color_hi = {req_item.red[7:3], req_item.green[7:5]};
      cmd.color_lo = {req_item.green[4:2], req_item.blue[7:3]};
      cmd.col_end  = {7'd0, width_ff} - 16'd1;
      cmd.row_end  = {7'd0, height_ff} - 16'd1;
      cmd.zeros    = zeros_raw[18] ? VALUE_MAX : zeros_raw[17:0];
   end

   assign full    = (count_ff == 2'd2);
   assign do_push = push && !full;
   assign do_pop  = head_pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= PANEL_WIDTH_RESET;
         height_ff <= PANEL_HEIGHT_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = queue_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* rtl/tlcs_back.sv */
// action sequencer and result queue
`timescale 1ns / 1ps
`default_nettype none
module tlcs_back (
   input  wire                clock,
   input  wire                reset,
   input  tlcs_pkg::head_type head,
   output logic               head_pop,
   output logic               empty,
   input  wire                pop,
   output tlcs_pkg::rsp_type  rsp_item
);
   import tlcs_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   rsp_type           outq_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   rsp_type           act;
   logic              at_last;
   logic              emit;
   logic              do_pop;

   always_comb begin
      if (head.cmd.action == ACTION_PIXEL) begin
         act     = pixel_action(head.cmd, step_ff);
         at_last = (step_ff == PIXEL_LAST);
      end else begin
         act     = init_action(head.cmd, step_ff);
         at_last = (step_ff == INIT_LAST);
      end
      act.last = at_last;
   end

   assign emit     = head.valid && (count_ff != 2'd2);
   assign head_pop = emit && at_last;
   assign empty    = (count_ff == 2'd0);
   assign do_pop   = pop && !empty;

   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = at_last ? '0 : step_ff + 1'b1;
      end
      wr_ptr_in = emit ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(emit) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         step_ff   <= step_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         outq_ff[wr_ptr_ff] <= act;
      end
   end

   assign rsp_item = outq_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* rtl/tft_lcd_command_sequencer.sv */
// top level of the tft lcd command sequencer
// usage:
//   request side is a queue: drive req_item and raise push while full is low;
//   action 0 asks for panel init and clear (33 bus actions), action 1 for a
//   single rgb565 pixel write (15 bus actions)
//   result side is a queue: while empty is low the oldest bus action sits
//   on rsp_item (kind, value, last); raise pop to take it. last marks the
//   final action of each request
//   csr channel writes panel_width (index 0) or panel_height (index 1);
//   csr_ready is always high, writes take effect on the next request
// timing:
//   front classifies and queues a request at the accepting edge; the back
//   sequencer emits one action per cycle while the result queue has room, and
//   the first action reaches rsp_item through the command queue and the result
//   queue registers. two requests can wait in the command queue
//   a stalled receiver fills the two-entry result queue and the sequencer
//   holds its step until space frees, then the command queue fills and full
//   rises; nothing is dropped
// reset: synchronous, clears both queues and the step counter and loads
//   panel size 240 x 320
`timescale 1ns / 1ps
`default_nettype none
module tft_lcd_command_sequencer (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                push,
   output logic               full,
   input  tlcs_pkg::req_type  req_item,
   // result channel
   output logic               empty,
   input  wire                pop,
   output tlcs_pkg::rsp_type  rsp_item,
   // configuration channel
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire                csr_index,
   input  wire [8:0]          csr_data
);
   import tlcs_pkg::*;

   head_type head;
   logic     head_pop;

   // registers are always writable
   assign csr_ready = 1'b1;

   // front: panel registers, classification, command queue
   tlcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .head      (head),
      .head_pop  (head_pop)
   );

   // back: step sequencer and result queue
   tlcs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .head_pop (head_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire

/* sim/tlcs_checker.sv */
// action predictor and result checker for the tft lcd command sequencer testbench
`timescale 1ns / 1ps
module tlcs_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire               full,
   input  tlcs_pkg::req_type req_item,
   input  wire               rsp_empty,
   input  wire               pop,
   input  tlcs_pkg::rsp_type rsp_item,
   input  wire               csr_valid,
   input  wire               csr_ready,
   input  wire               csr_index,
   input  wire [8:0]         csr_data,
   output int unsigned       errors,
   output int unsigned       pending
);
   import tlcs_pkg::*;

   rsp_type     action_queue[$];
   logic [8:0]  width_reg;
   logic [8:0]  height_reg;
   int unsigned mismatch_count;

   function automatic void add_action(input kind_type k, input logic [17:0] v);
      rsp_type a;
      a.kind  = k;
      a.value = v;
      a.last  = 1'b0;
      action_queue.push_back(a);
   endfunction

   // address set command with 16-bit start and end
   function automatic void add_window(input logic [7:0] op, input logic [15:0] lo,
                                      input logic [15:0] hi);
      add_action(KIND_CMD, {10'd0, op});
      add_action(KIND_DATA, {10'd0, lo[15:8]});
      add_action(KIND_DATA, {10'd0, lo[7:0]});
      add_action(KIND_DATA, {10'd0, hi[15:8]});
      add_action(KIND_DATA, {10'd0, hi[7:0]});
   endfunction

   function automatic void predict_actions(input req_type r);
      int unsigned zeros;
      logic [15:0] col_end;
      logic [15:0] row_end;
      logic [7:0]  color_hi;
      logic [7:0]  color_lo;
      if (r.action == ACTION_INIT) begin
         zeros = width_reg;
         zeros = zeros * height_reg * 2;
         if (zeros > VALUE_MAX) zeros = VALUE_MAX;
         col_end = {7'd0, width_reg} - 16'd1;
         row_end = {7'd0, height_reg} - 16'd1;
         add_action(KIND_RESET, 18'd1);
         add_action(KIND_SELECT, 18'd1);
         add_action(KIND_RESET, 18'd0);
         add_action(KIND_WAIT, WAIT_RESET_MS);
         add_action(KIND_RESET, 18'd1);
         add_action(KIND_WAIT, WAIT_LONG_MS);
         add_action(KIND_SELECT, 18'd0);
         add_action(KIND_CMD, {10'd0, OP_SWRESET});
         add_action(KIND_SELECT, 18'd1);
         add_action(KIND_WAIT, WAIT_SWRST_MS);
         add_action(KIND_SELECT, 18'd0);
         add_action(KIND_CMD, {10'd0, OP_SLPOUT});
         add_action(KIND_WAIT, WAIT_LONG_MS);
         add_action(KIND_CMD, {10'd0, OP_COLMOD});
         add_action(KIND_DATA, {10'd0, MODE_RGB565});
         add_action(KIND_CMD, {10'd0, OP_MADCTL});
         add_action(KIND_DATA, 18'd0);
         add_action(KIND_CMD, {10'd0, OP_INVON});
         add_action(KIND_CMD, {10'd0, OP_NORON});
         add_window(OP_CASET, 16'd0, col_end);
         add_window(OP_RASET, 16'd0, row_end);
         add_action(KIND_CMD, {10'd0, OP_RAMWR});
         add_action(KIND_ZEROS, zeros[17:0]);
         add_action(KIND_CMD, {10'd0, OP_DISPON});
         add_action(KIND_SELECT, 18'd1);
      end else begin
         color_hi = {r.red[7:3], r.green[7:5]};
         color_lo = {r.green[4:2], r.blue[7:3]};
         add_action(KIND_SELECT, 18'd0);
         add_window(OP_CASET, {7'd0, r.pos_x}, {7'd0, r.pos_x});
         add_window(OP_RASET, {7'd0, r.pos_y}, {7'd0, r.pos_y});
         add_action(KIND_CMD, {10'd0, OP_RAMWR});
         add_action(KIND_DATA, {10'd0, color_hi});
         add_action(KIND_DATA, {10'd0, color_lo});
         add_action(KIND_SELECT, 18'd1);
      end
      action_queue[action_queue.size() - 1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         action_queue.delete();
         width_reg      = PANEL_WIDTH_RESET;
         height_reg     = PANEL_HEIGHT_RESET;
         mismatch_count = 0;
         errors  <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PANEL_WIDTH) width_reg = csr_data;
            else height_reg = csr_data;
         end
         if (push && !full) predict_actions(req_item);
         if (pop && !rsp_empty) begin
            if (action_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected action: kind %0d value %0d last %0d",
                           rsp_item.kind, rsp_item.value, rsp_item.last);
            end else begin
               want = action_queue.pop_front();
               if (want.kind != rsp_item.kind || want.value != rsp_item.value ||
                   want.last != rsp_item.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"action mismatch: expected kind %0d value %0d last %0d,",
                               " got kind %0d value %0d last %0d"},
                              want.kind, want.value, want.last,
                              rsp_item.kind, rsp_item.value, rsp_item.last);
               end
            end
         end
         errors  <= mismatch_count;
         pending <= action_queue.size();
      end
   end

endmodule

/* sim/tb.sv */
// testbench top for the tft lcd command sequencer: stimulus and verdict
`timescale 1ns / 1ps
module tb;
   import tlcs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned ITEMS_PER_PHASE = 80;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        push      = 1'b0;
   req_type     req_item  = '0;
   logic        pop       = 1'b0;
   logic        csr_valid = 1'b0;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_data  = 9'd0;
   logic        full;
   logic        empty;
   logic        csr_ready;
   rsp_type     rsp_item;

   int unsigned errors;
   int unsigned pending;
   int unsigned cycle_count = 0;
   // idling odds in percent, changed per phase
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;

   tft_lcd_command_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .empty     (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   tlcs_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .rsp_empty (empty),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .errors    (errors),
      .pending   (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver: pop held low on a stall cycle
   always @(posedge clock) begin
      pop <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // offer one item, optionally after an idle gap; returns at the accepting edge
   // with push still high so a back-to-back item needs no second assignment
   task automatic send_req(input req_type r);
      logic ok;
      if ($urandom_range(99) < idle_pct) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      push     <= 1'b1;
      req_item <= r;
      ok = 1'b0;
      // full is stable between edges, so look at it mid-cycle
      while (!ok) begin
         @(negedge clock);
         ok = !full;
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic idx, input logic [8:0] val);
      logic ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      ok = 1'b0;
      while (!ok) begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drain every outstanding action, then let the sequencer settle
   task automatic wait_idle();
      push <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   // panel size is only changed with the sequencer idle
   task automatic set_panel(input logic [8:0] w, input logic [8:0] h);
      wait_idle();
      write_csr(CSR_PANEL_WIDTH, w);
      write_csr(CSR_PANEL_HEIGHT, h);
   endtask

   function automatic req_type pixel_req(input logic [8:0] x, input logic [8:0] y,
                                         input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
      req_type q;
      q.action = ACTION_PIXEL;
      q.pos_x  = x;
      q.pos_y  = y;
      q.red    = r;
      q.green  = g;
      q.blue   = b;
      return q;
   endfunction

   // init request with random junk in the ignored fields
   function automatic req_type init_req();
      req_type q;
      q = req_type'({$urandom, $urandom});
      q.action = ACTION_INIT;
      return q;
   endfunction

   // mostly real panel sizes, sometimes zero, one or the full register range
   function automatic logic [8:0] pick_size();
      case ($urandom_range(9))
         0: return 9'd0;
         1: return 9'd1;
         2: return 9'd320;
         3: return 9'd511;
         default: return 9'($urandom_range(1, 320));
      endcase
   endfunction

   function automatic req_type random_req();
      logic [8:0] x;
      logic [8:0] y;
      if ($urandom_range(99) < 12) return init_req();
      // coordinates mostly on the panel, now and then anywhere in 9 bits
      x = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 319));
      y = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 319));
      return pixel_req(x, y, 8'($urandom), 8'($urandom), 8'($urandom));
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset-time panel size, then pixel extremes
      send_req(init_req());
      send_req(pixel_req(9'd0, 9'd0, 8'h00, 8'h00, 8'h00));
      send_req(pixel_req(9'd319, 9'd319, 8'hFF, 8'hFF, 8'hFF));
      send_req(pixel_req(9'd256, 9'd170, 8'hAA, 8'h55, 8'hAA));
      send_req(pixel_req(9'd85, 9'd256, 8'h55, 8'hAA, 8'h55));
      // pixel far outside the panel is still sent and checked
      send_req(pixel_req(9'd511, 9'd511, 8'h07, 8'h1C, 8'h07));
      // init ignores all pixel fields
      send_req(init_req());

      // zero panel: window end wraps to all ones, zero run count 0
      set_panel(9'd0, 9'd0);
      send_req(init_req());
      // oversized panel: zero run count saturates
      set_panel(9'd511, 9'd511);
      send_req(init_req());
      send_req(pixel_req(9'd1, 9'd2, 8'h80, 8'h04, 8'h08));
      set_panel(9'd1, 9'd1);
      send_req(init_req());
      set_panel(9'd320, 9'd320);
      send_req(init_req());
      set_panel(9'd320, 9'd1);
      send_req(init_req());
      set_panel(9'd1, 9'd320);
      send_req(init_req());

      // random phases: no idling, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         set_panel(pick_size(), pick_size());
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // the second half of each phase runs without idling or stalls
            if (i == ITEMS_PER_PHASE / 2) begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            send_req(random_req());
         end
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
